// ===== sv/slfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subtractive lagged-Fibonacci generator package
// Shared constants, the controller state type and small index and modular
// arithmetic helpers.
// ----------------------------------------------------------------------------
package slfr_pkg;

   localparam int LAG_LEN    = 55;
   localparam int LAG_SHORT  = 24;
   localparam int FILL_STEP  = 21;
   localparam int WARMUP     = 165;
   localparam int VALUE_W    = 30;
   localparam int SEED_W     = 32;
   localparam int IDX_W      = 6;
   localparam int WARM_W     = 8;
   localparam int DIV_CNT_W  = 1;

   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [IDX_W-1:0]   index_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DIV   = 6'b000010,
      ST_FIX   = 6'b000100,
      ST_FILL  = 6'b001000,
      ST_ISSUE = 6'b010000,
      ST_CALC  = 6'b100000
   } state_type;

   function automatic index_type step_down(input index_type idx);
      index_type res;
      if (idx == '0 || idx > index_type'(LAG_LEN - 1)) begin
         res = index_type'(LAG_LEN - 1);
      end else begin
         res = idx - index_type'(1);
      end
      return res;
   endfunction

   function automatic value_type sub_mod(input value_type x, input value_type y,
                                         input logic [VALUE_W:0] m);
      value_type res;
      if (x >= y) begin
         res = x - y;
      end else begin
         res = VALUE_W'({1'b0, x} + m - {1'b0, y});
      end
      return res;
   endfunction

endpackage

// ===== sv/subtractive_lagged_fibonacci_rng.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subtractive lagged-Fibonacci random number generator
// Lags 55 and 24 modulo MODULUS, with the lag table kept in a dual-read
// synchronous memory.
// ----------------------------------------------------------------------------
// A draw word (cmd = 1) returns one value below MODULUS in a read step and a
// compute step: the read step reads both lag entries from the table memory, the
// compute step subtracts and writes the result back while loading the output register.
// A reseed word (cmd = 0) returns nothing and keeps the block busy while it
// reduces the seed by reciprocal multiplication, corrects the sign, fills the
// table one entry per cycle and runs discarded draws, which overlap the read of
// one draw with the write-back of the previous one. A draw that finds the output
// register still held waits until it is taken. Before any reseed the table
// reads as zeros.
module subtractive_lagged_fibonacci_rng #(
   parameter int unsigned MODULUS = 1000000000
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_cmd,
   input  logic signed [slfr_pkg::SEED_W-1:0]    req_seed,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic        [slfr_pkg::VALUE_W-1:0]   rsp_value
);

   localparam logic [slfr_pkg::VALUE_W:0] MOD_W = (slfr_pkg::VALUE_W + 1)'(MODULUS);
   localparam logic [slfr_pkg::SEED_W-1:0] MOD_S = slfr_pkg::SEED_W'(MODULUS);
   localparam logic [slfr_pkg::SEED_W-1:0] RECIP =
      slfr_pkg::SEED_W'((64'd1 << 32) / MODULUS);

   slfr_pkg::state_type state_ff, state_in;
   slfr_pkg::index_type long_ff, long_in;
   slfr_pkg::index_type short_ff, short_in;
   slfr_pkg::index_type pos_ff, pos_in;
   slfr_pkg::index_type fill_cnt_ff, fill_cnt_in;
   logic [slfr_pkg::WARM_W-1:0]    warm_cnt_ff, warm_cnt_in;
   logic                           warm_ff, warm_in;
   logic [slfr_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [slfr_pkg::SEED_W-1:0]    mag_ff, mag_in;
   logic [slfr_pkg::SEED_W-1:0]    quo_ff, quo_in;
   logic                           neg_ff, neg_in;
   slfr_pkg::value_type rem_ff, rem_in;
   slfr_pkg::value_type last_ff, last_in;
   slfr_pkg::value_type next_ff, next_in;
   logic                rsp_valid_ff, rsp_valid_in;
   slfr_pkg::value_type rsp_value_ff, rsp_value_in;

   slfr_pkg::value_type mem [slfr_pkg::LAG_LEN];
   logic [slfr_pkg::LAG_LEN-1:0] vld_ff;
   slfr_pkg::value_type rd_long_ff, rd_short_ff;
   logic                rd_long_vld_ff, rd_short_vld_ff;

   logic                rd_en;
   slfr_pkg::index_type rd_addr_long, rd_addr_short;
   logic                wr_en;
   slfr_pkg::index_type wr_addr;
   slfr_pkg::value_type wr_data;

   logic                req_accept;
   logic                slot_free;
   logic                rsp_load;
   slfr_pkg::value_type lag_long, lag_short, diff;
   logic [2*slfr_pkg::SEED_W-1:0] recip_prod;
   logic [slfr_pkg::SEED_W-1:0]   quo_mod;
   logic [slfr_pkg::SEED_W-1:0]   rem_est;
   slfr_pkg::value_type fix_value;
   logic [slfr_pkg::IDX_W:0] pos_sum;

   assign req_stall  = (state_ff != slfr_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   assign rd_addr_long  = slfr_pkg::step_down(long_ff);
   assign rd_addr_short = slfr_pkg::step_down(short_ff);

   assign lag_long  = rd_long_vld_ff  ? rd_long_ff  : '0;
   assign lag_short = rd_short_vld_ff ? rd_short_ff : '0;
   assign diff      = slfr_pkg::sub_mod(lag_long, lag_short, MOD_W);

   assign recip_prod = mag_ff * RECIP;
   assign quo_mod    = quo_ff * MOD_S;
   assign rem_est    = mag_ff - quo_mod;
   assign fix_value = (neg_ff && rem_ff != '0)
                    ? slfr_pkg::VALUE_W'(MOD_W - {1'b0, rem_ff}) : rem_ff;
   assign pos_sum   = {1'b0, pos_ff} + (slfr_pkg::IDX_W + 1)'(slfr_pkg::FILL_STEP);

   always_comb begin
      state_in     = state_ff;
      long_in      = long_ff;
      short_in     = short_ff;
      pos_in       = pos_ff;
      fill_cnt_in  = fill_cnt_ff;
      warm_cnt_in  = warm_cnt_ff;
      warm_in      = warm_ff;
      div_cnt_in   = div_cnt_ff;
      mag_in       = mag_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      last_in      = last_ff;
      next_in      = next_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = long_ff;
      wr_data      = diff;
      rsp_load     = 1'b0;

      unique case (state_ff)
         slfr_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_cmd) begin
                  rd_en    = 1'b1;
                  long_in  = rd_addr_long;
                  short_in = rd_addr_short;
                  warm_in  = 1'b0;
                  state_in = slfr_pkg::ST_CALC;
               end else begin
                  neg_in     = req_seed[slfr_pkg::SEED_W-1];
                  mag_in     = req_seed[slfr_pkg::SEED_W-1]
                             ? ($unsigned(~req_seed) + slfr_pkg::SEED_W'(1))
                             : $unsigned(req_seed);
                  rem_in     = '0;
                  div_cnt_in = '0;
                  state_in   = slfr_pkg::ST_DIV;
               end
            end
         end
         slfr_pkg::ST_DIV: begin
            div_cnt_in = div_cnt_ff + slfr_pkg::DIV_CNT_W'(1);
            if (div_cnt_ff == '1) begin
               rem_in   = (rem_est >= MOD_S)
                        ? slfr_pkg::VALUE_W'(rem_est - MOD_S)
                        : slfr_pkg::VALUE_W'(rem_est);
               state_in = slfr_pkg::ST_FIX;
            end else begin
               quo_in = recip_prod[2*slfr_pkg::SEED_W-1:slfr_pkg::SEED_W];
            end
         end
         slfr_pkg::ST_FIX: begin
            wr_en       = 1'b1;
            wr_addr     = '0;
            wr_data     = fix_value;
            last_in     = fix_value;
            next_in     = slfr_pkg::VALUE_W'(1);
            pos_in      = slfr_pkg::IDX_W'(slfr_pkg::FILL_STEP);
            fill_cnt_in = slfr_pkg::IDX_W'(1);
            state_in    = slfr_pkg::ST_FILL;
         end
         slfr_pkg::ST_FILL: begin
            wr_en       = 1'b1;
            wr_addr     = pos_ff;
            wr_data     = next_ff;
            last_in     = next_ff;
            next_in     = slfr_pkg::sub_mod(last_ff, next_ff, MOD_W);
            pos_in      = (pos_sum >= (slfr_pkg::IDX_W + 1)'(slfr_pkg::LAG_LEN))
                        ? slfr_pkg::IDX_W'(pos_sum
                                           - (slfr_pkg::IDX_W + 1)'(slfr_pkg::LAG_LEN))
                        : pos_sum[slfr_pkg::IDX_W-1:0];
            fill_cnt_in = fill_cnt_ff + slfr_pkg::IDX_W'(1);
            if (fill_cnt_ff == slfr_pkg::IDX_W'(slfr_pkg::LAG_LEN - 1)) begin
               long_in     = '0;
               short_in    = slfr_pkg::IDX_W'(slfr_pkg::LAG_SHORT);
               warm_cnt_in = slfr_pkg::WARM_W'(slfr_pkg::WARMUP);
               state_in    = slfr_pkg::ST_ISSUE;
            end
         end
         slfr_pkg::ST_ISSUE: begin
            rd_en       = 1'b1;
            long_in     = rd_addr_long;
            short_in    = rd_addr_short;
            warm_cnt_in = warm_cnt_ff - slfr_pkg::WARM_W'(1);
            warm_in     = 1'b1;
            state_in    = slfr_pkg::ST_CALC;
         end
         slfr_pkg::ST_CALC: begin
            wr_en = 1'b1;
            if (warm_ff) begin
               if (warm_cnt_ff != '0) begin
                  rd_en       = 1'b1;
                  long_in     = rd_addr_long;
                  short_in    = rd_addr_short;
                  warm_cnt_in = warm_cnt_ff - slfr_pkg::WARM_W'(1);
               end else begin
                  state_in = slfr_pkg::ST_IDLE;
               end
            end else if (slot_free) begin
               rsp_load = 1'b1;
               state_in = slfr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = slfr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_value_in = rsp_value_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = diff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slfr_pkg::ST_IDLE;
         long_ff      <= '0;
         short_ff     <= slfr_pkg::IDX_W'(slfr_pkg::LAG_SHORT);
         warm_ff      <= 1'b0;
         warm_cnt_ff  <= '0;
         fill_cnt_ff  <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         long_ff      <= long_in;
         short_ff     <= short_in;
         warm_ff      <= warm_in;
         warm_cnt_ff  <= warm_cnt_in;
         fill_cnt_ff  <= fill_cnt_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      mag_ff       <= mag_in;
      quo_ff       <= quo_in;
      neg_ff       <= neg_in;
      rem_ff       <= rem_in;
      last_ff      <= last_in;
      next_ff      <= next_in;
      rsp_value_ff <= rsp_value_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_long_ff  <= mem[rd_addr_long];
         rd_short_ff <= mem[rd_addr_short];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff          <= '0;
         rd_long_vld_ff  <= 1'b0;
         rd_short_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_long_vld_ff  <= vld_ff[rd_addr_long];
            rd_short_vld_ff <= vld_ff[rd_addr_short];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

`ifndef SYNTHESIS
   a_no_same_entry_rw: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr_long != wr_addr && rd_addr_short != wr_addr))
      else $error("table read and write hit the same entry in one cycle");

   a_lag_distance: assert property (@(posedge clock) disable iff (reset)
      (short_ff == long_ff + slfr_pkg::IDX_W'(slfr_pkg::LAG_SHORT))
      || (short_ff + slfr_pkg::IDX_W'(slfr_pkg::LAG_LEN - slfr_pkg::LAG_SHORT) == long_ff))
      else $error("long and short indices lost their lag distance");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (long_ff <= slfr_pkg::IDX_W'(slfr_pkg::LAG_LEN - 1))
      && (short_ff <= slfr_pkg::IDX_W'(slfr_pkg::LAG_LEN - 1))
      && (pos_ff <= slfr_pkg::IDX_W'(slfr_pkg::LAG_LEN - 1)
          || state_ff != slfr_pkg::ST_FILL))
      else $error("table index out of range");

   a_load_only_on_draw: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (state_ff == slfr_pkg::ST_CALC && !warm_ff && rd_en == 1'b0))
      else $error("output loaded outside a user draw");

   a_value_below_modulus: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> ({1'b0, rsp_value_ff} < MOD_W))
      else $error("drawn value not below the modulus");
`endif

endmodule
